[src/hdf_pkg.sv]
package hdf_pkg;

  localparam int unsigned LINE_W = 20;
  localparam logic [LINE_W-1:0] LINE_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } digest_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_index;
    logic              is_duplicate;
    logic [LINE_W-1:0] first_index;
    logic              starts_group;
    logic              table_full;
  } result_t;

endpackage

[src/hash_digest_duplicate_finder.sv]
// Duplicate finder for 128-bit digests, one digest per transaction.
// Input: a transaction is taken at the rising edge where start is high and
// busy is low; digest carries both 64-bit halves. The top BUCKET_BITS bits
// of digest_high pick a bucket whose chain of stored unique digests is walked.
// Output: done is high for exactly one cycle with result valid; the receiver
// cannot stall, so nothing is held back. Each input gives exactly one result.
// Sequence: after acceptance busy stays high through a head step, compare steps
// over the chain entries until a match or the end of the chain, and a duplicate
// or new step; each chain step is one registered read of the entry memory in a
// single sequencer step. The result strobe is high in the cycle in which busy
// drops, and a new transaction may be started in that same cycle.
// Reset (rst, synchronous): counters clear and the sequencer runs a clearing
// pass over the bucket-head memory, one entry per cycle with busy high, before
// the first transaction is taken.
// Control is a six-step microprogram in a read-only table; each control word
// selects datapath actions and up to two conditional jumps.
module hash_digest_duplicate_finder #(
  parameter int unsigned MAX_UNIQUE  = 1024,
  parameter int unsigned BUCKET_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  hdf_pkg::digest_t   digest,
  output logic               busy,
  output logic               done,
  output hdf_pkg::result_t   result
);

  localparam int unsigned IW = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned AW = $clog2(MAX_UNIQUE);
  localparam int unsigned NB = 1 << BUCKET_BITS;
  localparam logic [IW-1:0] EMPTY = IW'(MAX_UNIQUE);

  typedef enum logic [2:0] {
    P_IDLE, P_HEAD, P_CMP, P_DUP, P_NEW, P_CLR
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NOT_START, C_END, C_NO_MATCH, C_CLR_MORE
  } cond_t;

  typedef struct packed {
    logic  busy;
    logic  load_in;
    logic  load_head;
    logic  walk;
    logic  dup_out;
    logic  new_out;
    logic  clear;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
  } ctrl_t;

  typedef struct packed {
    logic [63:0]               hi;
    logic [63:0]               lo;
    logic [hdf_pkg::LINE_W-1:0] first;
    logic [IW-1:0]             nxt;
  } entry_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t word;
    word = '0;
    word.cond_a = C_NEVER;
    word.tgt_a  = P_IDLE;
    word.cond_b = C_NEVER;
    word.tgt_b  = P_IDLE;
    unique case (s)
      P_IDLE: begin
        word.load_in = 1'b1;
        word.cond_a  = C_NOT_START;
        word.tgt_a   = P_IDLE;
      end
      P_HEAD: begin
        word.busy      = 1'b1;
        word.load_head = 1'b1;
      end
      P_CMP: begin
        word.busy   = 1'b1;
        word.walk   = 1'b1;
        word.cond_a = C_END;
        word.tgt_a  = P_NEW;
        word.cond_b = C_NO_MATCH;
        word.tgt_b  = P_CMP;
      end
      P_DUP: begin
        word.busy    = 1'b1;
        word.dup_out = 1'b1;
        word.cond_a  = C_ALWAYS;
        word.tgt_a   = P_IDLE;
      end
      P_NEW: begin
        word.busy    = 1'b1;
        word.new_out = 1'b1;
        word.cond_a  = C_ALWAYS;
        word.tgt_a   = P_IDLE;
      end
      P_CLR: begin
        word.busy   = 1'b1;
        word.clear  = 1'b1;
        word.cond_a = C_CLR_MORE;
        word.tgt_a  = P_CLR;
        word.cond_b = C_ALWAYS;
        word.tgt_b  = P_IDLE;
      end
      default: begin
        word.busy   = 1'b1;
        word.cond_a = C_ALWAYS;
        word.tgt_a  = P_IDLE;
      end
    endcase
    return word;
  endfunction

  // memories
  entry_t        ent_mem  [MAX_UNIQUE];
  logic          seen_mem [MAX_UNIQUE];
  logic [IW-1:0] head_mem [NB];

  step_t                      upc;
  step_t                      upc_next;
  ctrl_t                      cw;
  logic [BUCKET_BITS-1:0]     clr_addr;
  logic [IW-1:0]              uc;
  logic [hdf_pkg::LINE_W-1:0] line_count;
  hdf_pkg::digest_t           key;
  logic [IW-1:0]              head_q;
  logic [IW-1:0]              head_keep;
  logic [IW-1:0]              cur;
  logic [IW-1:0]              cur_next;
  entry_t                     ent_q;
  logic                       seen_q;
  logic                       end_hit;
  logic                       match;
  logic                       room;
  logic                       accept;
  logic [BUCKET_BITS-1:0]     key_bucket;
  logic [BUCKET_BITS-1:0]     in_bucket;
  logic                       head_we;
  logic [BUCKET_BITS-1:0]     head_waddr;
  logic [IW-1:0]              head_wdata;

  function automatic logic holds(cond_t c, logic st, logic en, logic mt, logic cm);
    logic r;
    r = 1'b0;
    unique case (c)
      C_NEVER:     r = 1'b0;
      C_ALWAYS:    r = 1'b1;
      C_NOT_START: r = !st;
      C_END:       r = en;
      C_NO_MATCH:  r = !mt;
      C_CLR_MORE:  r = cm;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  assign cw         = ucode(upc);
  assign busy       = cw.busy;
  assign accept     = cw.load_in && start;
  assign in_bucket  = digest.digest_high[63 -: BUCKET_BITS];
  assign key_bucket = key.digest_high[63 -: BUCKET_BITS];
  assign end_hit    = cur >= uc;
  assign match      = (ent_q.hi == key.digest_high) && (ent_q.lo == key.digest_low);
  assign room       = uc < EMPTY;

  always_comb begin
    logic cm;
    cm = clr_addr != {BUCKET_BITS{1'b1}};
    if (holds(cw.cond_a, start, end_hit, match, cm)) begin
      upc_next = cw.tgt_a;
    end else if (holds(cw.cond_b, start, end_hit, match, cm)) begin
      upc_next = cw.tgt_b;
    end else begin
      upc_next = step_t'(upc + 3'd1);
    end
  end

  always_comb begin
    if (cw.load_head) begin
      cur_next = head_q;
    end else if (cw.walk && !end_hit && !match) begin
      cur_next = ent_q.nxt;
    end else begin
      cur_next = cur;
    end
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = key_bucket;
    head_wdata = uc;
    if (cw.clear) begin
      head_we    = 1'b1;
      head_waddr = clr_addr;
      head_wdata = EMPTY;
    end else if (cw.new_out && room) begin
      head_we = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc        <= P_CLR;
      clr_addr   <= '0;
      uc         <= '0;
      line_count <= '0;
      done       <= 1'b0;
    end else begin
      upc  <= upc_next;
      done <= cw.dup_out || cw.new_out;
      if (cw.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cw.new_out && room) begin
        uc <= uc + 1'b1;
      end
      if ((cw.dup_out || cw.new_out) && line_count != hdf_pkg::LINE_MAX) begin
        line_count <= line_count + 1'b1;
      end
    end
  end

  // datapath registers and result
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    ent_q  <= ent_mem[cur_next[AW-1:0]];
    seen_q <= seen_mem[cur_next[AW-1:0]];
    if (accept) begin
      key    <= digest;
      head_q <= head_mem[in_bucket];
    end
    if (cw.load_head) begin
      head_keep <= head_q;
    end
    if (cw.dup_out || cw.new_out) begin
      result.line_index   <= line_count;
      result.is_duplicate <= cw.dup_out;
      result.first_index  <= cw.dup_out ? ent_q.first : line_count;
      result.starts_group <= cw.dup_out && !seen_q;
      result.table_full   <= cw.new_out && !room;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (!rst && head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (!rst && cw.new_out && room) begin
      ent_mem[uc[AW-1:0]]  <= '{hi: key.digest_high, lo: key.digest_low,
                                first: line_count, nxt: head_keep};
    end
    if (!rst && cw.new_out && room) begin
      seen_mem[uc[AW-1:0]] <= 1'b0;
    end else if (!rst && cw.dup_out) begin
      seen_mem[cur[AW-1:0]] <= 1'b1;
    end
  end

endmodule

[src/hdf_checker.sv]
module hdf_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input hdf_pkg::digest_t digest,
  input logic             busy,
  input logic             done,
  input hdf_pkg::result_t result
);

  // an accepted transaction keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  a_new_own_index: assert property (@(posedge clk) disable iff (rst)
    (done && !result.is_duplicate) |-> (result.first_index == result.line_index))
    else $error("new digest reports a foreign first index");

  a_group_dup: assert property (@(posedge clk) disable iff (rst)
    (done && result.starts_group) |-> (result.is_duplicate && !result.table_full))
    else $error("group start on a non-duplicate");

  a_full_not_dup: assert property (@(posedge clk) disable iff (rst)
    (done && result.table_full) |-> !result.is_duplicate)
    else $error("table full flagged on a duplicate");

endmodule

bind hash_digest_duplicate_finder hdf_checker u_hdf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .digest (digest),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[dv/tb_top.sv]
module tb_top;

  localparam int unsigned MAX_UNIQUE  = 1024;
  localparam int unsigned BUCKET_BITS = 16;
  localparam int unsigned N_BUCKETS   = 1 << BUCKET_BITS;
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned N_RANDOM    = 400;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  hdf_pkg::digest_t digest = '0;
  logic             busy;
  logic             done;
  hdf_pkg::result_t result;

  hash_digest_duplicate_finder #(
    .MAX_UNIQUE(MAX_UNIQUE),
    .BUCKET_BITS(BUCKET_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .digest(digest),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the digest table
  logic [63:0]                tbl_high  [MAX_UNIQUE];
  logic [63:0]                tbl_low   [MAX_UNIQUE];
  logic [hdf_pkg::LINE_W-1:0] tbl_first [MAX_UNIQUE];
  logic                       tbl_seen  [MAX_UNIQUE];
  int unsigned                tbl_next  [MAX_UNIQUE];
  int unsigned                head_of   [N_BUCKETS];
  int unsigned                uniq_cnt = 0;
  logic [hdf_pkg::LINE_W-1:0] line_cnt = '0;

  hdf_pkg::result_t expected_q[$];
  hdf_pkg::digest_t stored_log[$];
  int unsigned      err_cnt = 0;
  int unsigned      n_items = 0;
  int unsigned      n_dup = 0;
  int unsigned      n_group = 0;
  int unsigned      n_full = 0;
  int unsigned      idle_cycles = 0;

  function automatic hdf_pkg::result_t look_up_digest(hdf_pkg::digest_t d);
    hdf_pkg::result_t r;
    int unsigned      b;
    int unsigned      e;
    int unsigned      steps;
    bit               hit;
    r = '0;
    r.line_index = line_cnt;
    r.first_index = line_cnt;
    b = 32'(d.digest_high[63 -: BUCKET_BITS]);
    e = head_of[b];
    steps = 0;
    hit = 1'b0;
    while (!hit && e < uniq_cnt && e < MAX_UNIQUE && steps < MAX_UNIQUE) begin
      if (tbl_high[e] == d.digest_high && tbl_low[e] == d.digest_low) begin
        hit = 1'b1;
        r.is_duplicate = 1'b1;
        r.first_index = tbl_first[e];
        if (!tbl_seen[e]) begin
          r.starts_group = 1'b1;
          tbl_seen[e] = 1'b1;
        end
      end else begin
        e = tbl_next[e];
        steps++;
      end
    end
    if (!hit) begin
      if (uniq_cnt < MAX_UNIQUE) begin
        tbl_high[uniq_cnt] = d.digest_high;
        tbl_low[uniq_cnt] = d.digest_low;
        tbl_first[uniq_cnt] = line_cnt;
        tbl_seen[uniq_cnt] = 1'b0;
        tbl_next[uniq_cnt] = head_of[b];
        head_of[b] = uniq_cnt;
        uniq_cnt++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    if (line_cnt != hdf_pkg::LINE_MAX) line_cnt++;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_digest(input hdf_pkg::digest_t d);
    hdf_pkg::result_t r;
    @(negedge clk);
    start <= 1'b1;
    digest <= d;
    do @(posedge clk); while (busy);
    r = look_up_digest(d);
    expected_q.push_back(r);
    n_items++;
    if (r.is_duplicate) n_dup++;
    if (r.starts_group) n_group++;
    if (r.table_full) n_full++;
    if (!r.is_duplicate && !r.table_full) stored_log.push_back(d);
  endtask

  task automatic pause_sender(input int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    hdf_pkg::result_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected, line_index %0d",
               result.line_index);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        report_field("line_index", 32'(want.line_index), 32'(result.line_index));
        report_field("is_duplicate", 32'(want.is_duplicate),
                     32'(result.is_duplicate));
        report_field("first_index", 32'(want.first_index), 32'(result.first_index));
        report_field("starts_group", 32'(want.starts_group),
                     32'(result.starts_group));
        report_field("table_full", 32'(want.table_full), 32'(result.table_full));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("** hash_digest_duplicate_finder: FAILED **");
      $finish;
    end
  end

  task automatic test_directed();
    hdf_pkg::digest_t zeros;
    hdf_pkg::digest_t ones;
    hdf_pkg::digest_t mix;
    zeros = '0;
    ones = '1;
    mix = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
    send_digest(zeros);
    send_digest(zeros);
    send_digest(zeros);
    send_digest(ones);
    send_digest({64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
    send_digest(ones);
    send_digest({64'hFFFF_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF});
    send_digest(mix);
    send_digest(~mix);
    send_digest({64'h8000_0000_0000_0000, 64'h1});
    send_digest({64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000});
    send_digest({64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000});
    send_digest({64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
    send_digest(~mix);
    send_digest({64'h0, 64'h1});
    pause_sender(7);
    send_digest(zeros);
    send_digest({64'hFFFF_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF});
    send_digest(ones);
    send_digest(mix);
    send_digest({64'h0, 64'h1});
    send_digest({64'h0000_FFFF_FFFF_FFFF, 64'h0});
  endtask

  task automatic test_random();
    int unsigned      hot[4];
    int unsigned      pick;
    int unsigned      k;
    bit               idling;
    hdf_pkg::digest_t d;
    foreach (hot[i]) hot[i] = $urandom_range(0, N_BUCKETS - 1);
    idling = 1'b1;
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) idling = ($urandom_range(0, 9) < 7);
      pick = $urandom_range(0, 99);
      if (stored_log.size() == 0 || pick < 45) begin
        d = {rand64(), rand64()};
        if ($urandom_range(0, 3) == 0)
          d.digest_high[63 -: BUCKET_BITS] = BUCKET_BITS'(hot[$urandom_range(0, 3)]);
      end else if (pick < 80) begin
        d = stored_log[$urandom_range(0, stored_log.size() - 1)];
      end else if (pick < 90) begin
        // near miss: one bit away from a stored digest
        d = stored_log[$urandom_range(0, stored_log.size() - 1)];
        k = $urandom_range(0, 127);
        d[k] = ~d[k];
      end else begin
        // chain collision: same upper half, new lower half
        d = stored_log[$urandom_range(0, stored_log.size() - 1)];
        d.digest_low = rand64();
      end
      send_digest(d);
      if (idling && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 19));
    end
  endtask

  task automatic test_table_full();
    hdf_pkg::digest_t rejected;
    while (uniq_cnt < MAX_UNIQUE) send_digest({rand64(), rand64()});
    rejected = {rand64(), rand64()};
    send_digest(rejected);
    send_digest(rejected);
    repeat (10) send_digest({rand64(), rand64()});
    repeat (20) send_digest(stored_log[$urandom_range(0, stored_log.size() - 1)]);
    send_digest(stored_log[MAX_UNIQUE - 1]);
    send_digest(stored_log[MAX_UNIQUE - 1]);
    send_digest(rejected);
  endtask

  initial begin
    foreach (head_of[i]) head_of[i] = MAX_UNIQUE;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_table_full();
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d digests checked: %0d duplicates, %0d groups, %0d rejected as table full",
             n_items, n_dup, n_group, n_full);
    $display("table filled with %0d unique digests, then overflowed", uniq_cnt);
    if (err_cnt == 0) begin
      $display("** hash_digest_duplicate_finder: PASSED **");
    end else begin
      $display("** hash_digest_duplicate_finder: FAILED **");
    end
    $finish;
  end

endmodule
